>>> src/iq_nco_mixer_level_tracker_defines.svh
// ----------------------------------------------------------------------------
// IQ NCO mixer level tracker - assertion macros
// Shared concurrent assertion forms used by the RTL modules of the block.
// ----------------------------------------------------------------------------
`ifndef IQ_NCO_MIXER_LEVEL_TRACKER_DEFINES_SVH
`define IQ_NCO_MIXER_LEVEL_TRACKER_DEFINES_SVH

// A property that must hold at every clock edge outside reset.
`define IQMIX_ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define IQMIX_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define IQMIX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/iqmix_pkg.sv
// ----------------------------------------------------------------------------
// iqmix_pkg
// Constants, types and the oscillator table function of the IQ NCO mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package iqmix_pkg;

    // Oscillator phase wraps at this modulus.
    localparam int unsigned PHASE_MODULUS = 2048000;
    localparam int unsigned PHASE_W       = $clog2(PHASE_MODULUS);

    // The cosine/sine table has 2^TABLE_BITS steps per turn.
    localparam int unsigned TABLE_BITS = 12;
    localparam int unsigned QUART_BITS = TABLE_BITS - 2;
    localparam int unsigned QUARTER    = 1 << QUART_BITS;

    // Index computation: floor(phase * 2^TABLE_BITS / PHASE_MODULUS) through a
    // reciprocal that underestimates by less than one, then one correction.
    localparam int unsigned IDX_SHIFT = 32;
    localparam logic [31:0] IDX_RECIP =
        32'((64'd1 << (IDX_SHIFT + TABLE_BITS)) / PHASE_MODULUS);

    // 2*pi in Q.30 and the number of Taylor terms after the first, used for the table.
    localparam logic [63:0] TWO_PI_Q30   = 64'd6746518852;
    localparam int unsigned TAYLOR_TERMS = 12;

    // Field widths.
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned FREQ_W   = 22;
    localparam int unsigned OSC_W    = 16;
    localparam int unsigned MIX_W    = 24;
    localparam int unsigned MAG_W    = 23;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned LEVEL_W  = 48;
    localparam int unsigned LEVEL_FR = 24;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(168);
    localparam logic [MAG_W-1:0]  MAG_MAX    = {MAG_W{1'b1}};

    // Queue between the front and back parts.
    localparam int unsigned QUEUE_DEPTH = 2;

    // One item after the front part: recentred samples and the new phase.
    typedef struct packed {
        logic signed [BYTE_W-1:0] a;
        logic signed [BYTE_W-1:0] b;
        logic [PHASE_W-1:0]       phase;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // Q.30 to Q.15 with negative values clamped to zero, half-up rounding and
    // saturation at the largest positive Q1.15 value.
    function automatic logic [OSC_W-1:0] q30_to_q15(input logic signed [63:0] v);
        logic signed [63:0] clamped;
        logic signed [63:0] rounded;
        clamped = (v < 64'sd0) ? 64'sd0 : v;
        rounded = (clamped + 64'sd16384) >>> 15;
        if (rounded > 64'sd32767) begin
            rounded = 64'sd32767;
        end
        return rounded[OSC_W-1:0];
    endfunction

    // First-quadrant cosine and sine for table step r, evaluated at
    // elaboration. Returns {cos, sin}, each Q1.15.
    function automatic logic [2*OSC_W-1:0] osc_entry(input logic [QUART_BITS-1:0] r);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tc;
        logic [63:0] ts;
        logic [63:0] pc;
        logic [63:0] ps;
        logic signed [63:0] sc;
        logic signed [63:0] ss;
        x  = ((64'(r) * TWO_PI_Q30) + (64'd1 << (TABLE_BITS - 1))) >> TABLE_BITS;
        x2 = (x * x) >> 30;
        tc = 64'd1 << 30;
        ts = x;
        sc = $signed(tc);
        ss = $signed(ts);
        for (int k = 1; k <= TAYLOR_TERMS; k++) begin
            pc = (tc * x2) >> 30;
            ps = (ts * x2) >> 30;
            case (k)
                1:       begin tc = pc / 2;   ts = ps / 6;   end
                2:       begin tc = pc / 12;  ts = ps / 20;  end
                3:       begin tc = pc / 30;  ts = ps / 42;  end
                4:       begin tc = pc / 56;  ts = ps / 72;  end
                5:       begin tc = pc / 90;  ts = ps / 110; end
                6:       begin tc = pc / 132; ts = ps / 156; end
                7:       begin tc = pc / 182; ts = ps / 210; end
                8:       begin tc = pc / 240; ts = ps / 272; end
                9:       begin tc = pc / 306; ts = ps / 342; end
                10:      begin tc = pc / 380; ts = ps / 420; end
                11:      begin tc = pc / 462; ts = ps / 506; end
                default: begin tc = pc / 552; ts = ps / 600; end
            endcase
            if (k[0]) begin
                sc = sc - $signed(tc);
                ss = ss - $signed(ts);
            end else begin
                sc = sc + $signed(tc);
                ss = ss + $signed(ts);
            end
        end
        return {q30_to_q15(sc), q30_to_q15(ss)};
    endfunction

endpackage

`default_nettype wire

>>> src/iq_nco_mixer_level_tracker.sv
// ----------------------------------------------------------------------------
// iq_nco_mixer_level_tracker
// Frequency-shifting mixer for raw I/Q bytes with a running level average.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready): one item is a raw I/Q byte pair in
//   offset binary and a signed phase step. The step is subtracted from the
//   oscillator phase before the item is mixed.
//   Output channel (o_valid / i_ready): one item per input item, carrying the
//   mixed real and imaginary parts (scaled by 2^-15), their L1 magnitude and
//   the integer part of the running level after this item.
//   Configuration: i_cfg_we writes i_cfg_wdata into the averaging gain
//   (Q0.24) at that clock edge. Write it only while no item is in flight.
// Sequencing:
//   The front part takes an item whenever the queue is not full and places
//   it in a two-entry queue. The back sequencer steps through each item in
//   turn (index division, table read, complex multiply, magnitude and the
//   level step, which uses a single shared 24x24 multiplier twice) and takes
//   a new item from the queue only once it has finished the last one.
// Reset and stalls:
//   Synchronous active-low reset clears the phase, the level and the queue,
//   and restores the gain to 168. While the receiver holds i_ready low the
//   finished item waits in the output register, the sequencer finishes the
//   next item and waits, and the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module iq_nco_mixer_level_tracker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [iqmix_pkg::BYTE_W-1:0]        i_i_byte,
    input  logic [iqmix_pkg::BYTE_W-1:0]        i_q_byte,
    input  logic signed [iqmix_pkg::FREQ_W-1:0] i_freq_offset,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [iqmix_pkg::MIX_W-1:0]  o_real_out,
    output logic signed [iqmix_pkg::MIX_W-1:0]  o_imag_out,
    output logic [iqmix_pkg::MAG_W-1:0]         o_magnitude,
    output logic [iqmix_pkg::MAG_W-1:0]         o_level,
    input  logic                                i_cfg_we,
    input  logic [iqmix_pkg::GAIN_W-1:0]        i_cfg_wdata
);

    // Averaging gain register.
    logic [iqmix_pkg::GAIN_W-1:0] r_ema_gain;

    // Front-to-queue and queue-to-back connections.
    logic                     w_push;
    iqmix_pkg::t_item         w_push_item;
    logic                     w_pop;
    iqmix_pkg::t_item         w_head;
    iqmix_pkg::t_queue_status w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ema_gain <= iqmix_pkg::GAIN_RESET;
        end else if (i_cfg_we) begin
            r_ema_gain <= i_cfg_wdata;
        end
    end

    // The front part owns the phase accumulator, so the phase of each item is
    // fixed in arrival order, independent of how far the back part lags.
    iqmix_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_i_byte      (i_i_byte),
        .i_q_byte      (i_q_byte),
        .i_freq_offset (i_freq_offset),
        .i_status      (w_status),
        .o_push        (w_push),
        .o_item        (w_push_item)
    );

    iqmix_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_item (w_push_item),
        .i_pop       (w_pop),
        .o_status    (w_status),
        .o_head      (w_head)
    );

    // The back part owns the level accumulator and the output register.
    iqmix_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_status    (w_status),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_gain      (r_ema_gain),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_real_out  (o_real_out),
        .o_imag_out  (o_imag_out),
        .o_magnitude (o_magnitude),
        .o_level     (o_level)
    );

endmodule

`default_nettype wire

>>> src/iqmix_front.sv
// ----------------------------------------------------------------------------
// iqmix_front
// Accepts items, recentres the sample bytes and advances the phase.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iq_nco_mixer_level_tracker_defines.svh"

module iqmix_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [iqmix_pkg::BYTE_W-1:0]          i_i_byte,
    input  logic [iqmix_pkg::BYTE_W-1:0]          i_q_byte,
    input  logic signed [iqmix_pkg::FREQ_W-1:0]   i_freq_offset,
    input  iqmix_pkg::t_queue_status              i_status,
    output logic                                  o_push,
    output iqmix_pkg::t_item                      o_item
);

    localparam int unsigned PW  = iqmix_pkg::PHASE_W;
    localparam int unsigned V_W = iqmix_pkg::FREQ_W + 2;
    localparam logic signed [V_W-1:0] MOD1 = V_W'(iqmix_pkg::PHASE_MODULUS);
    localparam logic signed [V_W-1:0] MOD2 = V_W'(2 * iqmix_pkg::PHASE_MODULUS);

    logic [PW-1:0]         r_phase;
    logic [PW-1:0]         n_phase;
    logic signed [V_W-1:0] w_v;
    logic signed [V_W-1:0] w_mod;

    // The step magnitude stays below two moduli, so the difference is at most
    // two moduli outside the range.
    assign w_v = $signed(V_W'(r_phase)) - V_W'(i_freq_offset);

    always_comb begin
        if (w_v < 0) begin
            w_mod = ((w_v + MOD1) < 0) ? (w_v + MOD2) : (w_v + MOD1);
        end else if (w_v >= MOD2) begin
            w_mod = w_v - MOD2;
        end else if (w_v >= MOD1) begin
            w_mod = w_v - MOD1;
        end else begin
            w_mod = w_v;
        end
    end

    assign n_phase = w_mod[PW-1:0];

    assign o_ready      = !i_status.full;
    assign o_push       = i_valid && o_ready;
    assign o_item.a     = $signed({~i_i_byte[iqmix_pkg::BYTE_W-1],
                                   i_i_byte[iqmix_pkg::BYTE_W-2:0]});
    assign o_item.b     = $signed({~i_q_byte[iqmix_pkg::BYTE_W-1],
                                   i_q_byte[iqmix_pkg::BYTE_W-2:0]});
    assign o_item.phase = n_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (o_push) begin
            r_phase <= n_phase;
        end
    end

    `IQMIX_ASSERT_ALWAYS(a_phase_in_range, i_clk, i_rst_n, r_phase < PW'(iqmix_pkg::PHASE_MODULUS), "phase accumulator left its range")

endmodule

`default_nettype wire

>>> src/iqmix_queue.sv
// ----------------------------------------------------------------------------
// iqmix_queue
// Short register queue that decouples the front part from the back part.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iq_nco_mixer_level_tracker_defines.svh"

module iqmix_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  iqmix_pkg::t_item         i_push_item,
    input  logic                     i_pop,
    output iqmix_pkg::t_queue_status o_status,
    output iqmix_pkg::t_item         o_head
);

    localparam int unsigned DEPTH = iqmix_pkg::QUEUE_DEPTH;
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    iqmix_pkg::t_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `IQMIX_ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH), "queue count above depth")
    `IQMIX_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, i_pop, r_count != '0, "pop from an empty queue")
    `IQMIX_ASSERT_IMPL(a_push_room, i_clk, i_rst_n, i_push && !i_pop, r_count != CNT_W'(DEPTH), "push into a full queue")

endmodule

`default_nettype wire

>>> src/iqmix_back.sv
// ----------------------------------------------------------------------------
// iqmix_back
// Sequencer that mixes one item with the oscillator and updates the level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "iq_nco_mixer_level_tracker_defines.svh"

module iqmix_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  iqmix_pkg::t_queue_status            i_status,
    input  iqmix_pkg::t_item                    i_head,
    output logic                                o_pop,
    input  logic [iqmix_pkg::GAIN_W-1:0]        i_gain,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [iqmix_pkg::MIX_W-1:0]  o_real_out,
    output logic signed [iqmix_pkg::MIX_W-1:0]  o_imag_out,
    output logic [iqmix_pkg::MAG_W-1:0]         o_magnitude,
    output logic [iqmix_pkg::MAG_W-1:0]         o_level
);

    localparam int unsigned PW    = iqmix_pkg::PHASE_W;
    localparam int unsigned TB    = iqmix_pkg::TABLE_BITS;
    localparam int unsigned QB    = iqmix_pkg::QUART_BITS;
    localparam int unsigned OW    = iqmix_pkg::OSC_W;
    localparam int unsigned MW    = iqmix_pkg::MIX_W;
    localparam int unsigned GW    = iqmix_pkg::GAIN_W;
    localparam int unsigned LW    = iqmix_pkg::LEVEL_W;
    localparam int unsigned LF    = iqmix_pkg::LEVEL_FR;
    localparam int unsigned MAGW  = iqmix_pkg::MAG_W;
    localparam int unsigned PIW   = PW + 32;
    localparam int unsigned CHK_W = TB + 1 + PW;

    localparam logic [1:0] QUAD_FIRST  = 2'd0;
    localparam logic [1:0] QUAD_SECOND = 2'd1;
    localparam logic [1:0] QUAD_THIRD  = 2'd2;

    typedef enum logic [13:0] {
        S_IDLE  = 14'h0001,
        S_IDX   = 14'h0002,
        S_CHK   = 14'h0004,
        S_CORR  = 14'h0008,
        S_ROM   = 14'h0010,
        S_OSC   = 14'h0020,
        S_MUL   = 14'h0040,
        S_SUM   = 14'h0080,
        S_MAG   = 14'h0100,
        S_DIFF  = 14'h0200,
        S_PLO   = 14'h0400,
        S_PHI   = 14'h0800,
        S_DELTA = 14'h1000,
        S_UPD   = 14'h2000
    } t_back_state;

    t_back_state r_state;
    t_back_state n_state;

    // Quarter-wave cosine/sine table, {cos, sin} per step.
    logic [2*OW-1:0] w_rom [iqmix_pkg::QUARTER];

    for (genvar g = 0; g < iqmix_pkg::QUARTER; g++) begin : g_rom
        assign w_rom[g] = iqmix_pkg::osc_entry(QB'(g));
    end

    logic signed [7:0]    r_a;
    logic signed [7:0]    r_b;
    logic [PW-1:0]        r_phase;
    logic [PIW-1:0]       r_prod_idx;
    logic [TB:0]          r_q_est;
    logic [CHK_W-1:0]     r_chk;
    logic [TB-1:0]        r_idx;
    logic [2*OW-1:0]      r_cs;
    logic [1:0]           r_quad;
    logic signed [OW-1:0] r_c;
    logic signed [OW-1:0] r_s;
    logic signed [MW-1:0] r_ac;
    logic signed [MW-1:0] r_bs;
    logic signed [MW-1:0] r_as;
    logic signed [MW-1:0] r_bc;
    logic signed [MW-1:0] r_re;
    logic signed [MW-1:0] r_im;
    logic [MAGW-1:0]      r_mag;
    logic                 r_neg;
    logic [LW-1:0]        r_u;
    logic [LW-1:0]        r_plo;
    logic [LW-1:0]        r_phi;
    logic [LW-1:0]        r_delta;
    logic [LW-1:0]        r_level_acc;
    logic [LW-1:0]        n_level_acc;
    logic                 r_out_valid;

    logic [TB:0]          w_q_next;
    logic [CHK_W-1:0]     w_scaled;
    logic signed [OW-1:0] w_cos;
    logic signed [OW-1:0] w_sin;
    logic [MW-1:0]        w_abs_re;
    logic [MW-1:0]        w_abs_im;
    logic [MW:0]          w_mag_sum;
    logic [LW-1:0]        w_target;
    logic [GW-1:0]        w_mul_op;
    logic [LW-1:0]        w_mul_prod;
    logic [LW:0]          w_lo_sum;
    logic                 w_out_free;

    assign w_q_next = r_q_est + 1'b1;
    assign w_scaled = CHK_W'({r_phase, {TB{1'b0}}});
    assign w_cos    = $signed(r_cs[2*OW-1:OW]);
    assign w_sin    = $signed(r_cs[OW-1:0]);

    assign w_abs_re  = r_re[MW-1] ? MW'(-r_re) : MW'(r_re);
    assign w_abs_im  = r_im[MW-1] ? MW'(-r_im) : MW'(r_im);
    assign w_mag_sum = {1'b0, w_abs_re} + {1'b0, w_abs_im};

    assign w_target = {{(LW - MAGW - LF){1'b0}}, r_mag, {LF{1'b0}}};

    // One multiplier serves both halves of the level step.
    assign w_mul_op   = (r_state == S_PLO) ? r_u[GW-1:0] : r_u[LW-1:GW];
    assign w_mul_prod = LW'(w_mul_op) * LW'(i_gain);

    // Negative steps round the fractional part toward minus infinity.
    assign w_lo_sum = {1'b0, r_plo} + (r_neg ? (LW+1)'({LF{1'b1}}) : '0);

    assign n_level_acc = r_neg ? (r_level_acc - r_delta) : (r_level_acc + r_delta);
    assign w_out_free  = !r_out_valid || i_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_status.empty;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_status.empty) begin
                         n_state = S_IDX;
                     end
            S_IDX:   n_state = S_CHK;
            S_CHK:   n_state = S_CORR;
            S_CORR:  n_state = S_ROM;
            S_ROM:   n_state = S_OSC;
            S_OSC:   n_state = S_MUL;
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_MAG;
            S_MAG:   n_state = S_DIFF;
            S_DIFF:  n_state = S_PLO;
            S_PLO:   n_state = S_PHI;
            S_PHI:   n_state = S_DELTA;
            S_DELTA: n_state = S_UPD;
            S_UPD:   if (w_out_free) begin
                         n_state = S_IDLE;
                     end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_a     <= i_head.a;
                r_b     <= i_head.b;
                r_phase <= i_head.phase;
            end
            S_IDX: begin
                r_prod_idx <= PIW'(r_phase) * PIW'(iqmix_pkg::IDX_RECIP);
            end
            S_CHK: begin
                r_q_est <= r_prod_idx[iqmix_pkg::IDX_SHIFT +: (TB + 1)];
                r_chk   <= CHK_W'(r_prod_idx[iqmix_pkg::IDX_SHIFT +: (TB + 1)] + 1'b1)
                           * CHK_W'(iqmix_pkg::PHASE_MODULUS);
            end
            S_CORR: begin
                r_idx <= (w_scaled >= r_chk) ? w_q_next[TB-1:0] : r_q_est[TB-1:0];
            end
            S_ROM: begin
                r_cs   <= w_rom[r_idx[QB-1:0]];
                r_quad <= r_idx[TB-1:QB];
            end
            S_OSC: begin
                unique case (r_quad)
                    QUAD_FIRST:  begin r_c <= w_cos;  r_s <= w_sin;  end
                    QUAD_SECOND: begin r_c <= -w_sin; r_s <= w_cos;  end
                    QUAD_THIRD:  begin r_c <= -w_cos; r_s <= -w_sin; end
                    default:     begin r_c <= w_sin;  r_s <= -w_cos; end
                endcase
            end
            S_MUL: begin
                r_ac <= MW'(r_a) * MW'(r_c);
                r_bs <= MW'(r_b) * MW'(r_s);
                r_as <= MW'(r_a) * MW'(r_s);
                r_bc <= MW'(r_b) * MW'(r_c);
            end
            S_SUM: begin
                r_re <= r_ac - r_bs;
                r_im <= r_as + r_bc;
            end
            S_MAG: begin
                r_mag <= (w_mag_sum > (MW+1)'(iqmix_pkg::MAG_MAX))
                         ? iqmix_pkg::MAG_MAX : w_mag_sum[MAGW-1:0];
            end
            S_DIFF: begin
                r_neg <= (w_target < r_level_acc);
                r_u   <= (w_target < r_level_acc) ? (r_level_acc - w_target)
                                                  : (w_target - r_level_acc);
            end
            S_PLO: begin
                r_plo <= w_mul_prod;
            end
            S_PHI: begin
                r_phi <= w_mul_prod;
            end
            S_DELTA: begin
                r_delta <= r_phi + LW'(w_lo_sum[LW:LF]);
            end
            S_UPD: begin
                if (w_out_free) begin
                    o_real_out  <= r_re;
                    o_imag_out  <= r_im;
                    o_magnitude <= r_mag;
                    o_level     <= n_level_acc[LF +: MAGW];
                end
            end
            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_level_acc <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_UPD) && w_out_free) begin
                r_level_acc <= n_level_acc;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    `IQMIX_ASSERT_ALWAYS(a_level_bound, i_clk, i_rst_n, r_level_acc[LW-1] == 1'b0, "level accumulator overflowed")
    `IQMIX_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_UPD) && w_out_free, r_out_valid && (r_state == S_IDLE), "finished item not loaded")

endmodule

`default_nettype wire
